>>> rtl/xoshiro_bounded_random_core_macros.svh
// Assertion macros for the bounded random generator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef XOSHIRO_BOUNDED_RANDOM_CORE_MACROS_SVH
`define XOSHIRO_BOUNDED_RANDOM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XBR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XBR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/xbr_pkg.sv
// Shared constants, types and helper functions of the bounded random generator.
// Used by xbr_mul, xbr_div and the top level; depends on nothing else.
`default_nettype none

package xbr_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned HALF_W    = WORD_W / 2;
    localparam int unsigned NUM_WORDS = 4;

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic signed [WORD_W-1:0] sword_t;
    typedef logic [HALF_W-1:0]        half_t;

    // Seed expansion constants.
    localparam word_t GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam word_t MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam word_t MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam int unsigned MIX_SHIFT_1 = 30;
    localparam int unsigned MIX_SHIFT_2 = 27;
    localparam int unsigned MIX_SHIFT_3 = 31;

    // Generator step constants.
    localparam int unsigned GEN_SHIFT   = 17;
    localparam int unsigned GEN_ROT     = 45;
    localparam int unsigned SCRAM_ROT   = 7;
    localparam int unsigned SCRAM_SHL_5 = 2;   // times 5 is x + 4x
    localparam int unsigned SCRAM_SHL_9 = 3;   // times 9 is x + 8x
    localparam int unsigned FRAC_SHIFT  = 11;  // keeps the top 53 bits

    localparam logic ACTION_BOUNDED  = 1'b0;
    localparam logic ACTION_FRACTION = 1'b1;

    function automatic word_t rotl(input word_t v, input int unsigned k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

endpackage

`default_nettype wire

>>> rtl/xoshiro_bounded_random_core.sv
// Top level of the bounded random generator: sequencer, generator state and
// output register. Uses xbr_pkg, xbr_mul, xbr_div and the assertion macros.
//
// The seed register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, which the block does not
// enforce. A write, and likewise reset, re-expands the seed into the four
// state words, during which s_ready is low. After reset the seed is zero.
// Each input item (s_action, s_range_low, s_range_high) yields exactly one
// result item on m_value. After acceptance, a fraction request passes the
// states DRAW1, DRAW2, USE and EMIT; an empty interval DECIDE and EMIT;
// a full span DECIDE, SPAN, DRAW1, DRAW2, USE and EMIT. A bounded request
// runs the bit-serial remainder unit twice, once for the rejection limit
// and once for the final reduction; each rejected draw adds another draw.
// That remainder unit, at one bit per cycle, sets the throughput. One item
// is worked on at a time; the next is taken in idle, after a result is written.
// The output register holds a finished result until m_ready takes it; the
// next item is accepted and computed meanwhile, and only waits to be
// written into the output register until the receiver has drained it.
`default_nettype none

module xoshiro_bounded_random_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // Seed register write port.
    input  wire logic            cfg_wr_en,
    input  wire xbr_pkg::word_t  cfg_wr_data,
    // Request channel.
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_action,
    input  wire xbr_pkg::sword_t s_range_low,
    input  wire xbr_pkg::sword_t s_range_high,
    // Result channel.
    output logic                 m_valid,
    input  wire logic            m_ready,
    output xbr_pkg::sword_t      m_value
);
    import xbr_pkg::*;

`include "xoshiro_bounded_random_core_macros.svh"

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEED_ADD = 4'd1;
    localparam logic [3:0] ST_MUL_A    = 4'd2;
    localparam logic [3:0] ST_WAIT_A   = 4'd3;
    localparam logic [3:0] ST_MUL_B    = 4'd4;
    localparam logic [3:0] ST_WAIT_B   = 4'd5;
    localparam logic [3:0] ST_DECIDE   = 4'd6;
    localparam logic [3:0] ST_SPAN     = 4'd7;
    localparam logic [3:0] ST_LIMIT    = 4'd8;
    localparam logic [3:0] ST_DRAW1    = 4'd9;
    localparam logic [3:0] ST_DRAW2    = 4'd10;
    localparam logic [3:0] ST_USE      = 4'd11;
    localparam logic [3:0] ST_MOD      = 4'd12;
    localparam logic [3:0] ST_EMIT     = 4'd13;

    localparam int unsigned IDX_W = $clog2(NUM_WORDS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_WORDS - 1);

    logic [3:0]       state_reg;
    logic [3:0]       state_next;

    // Seed expansion registers.
    word_t            acc_reg;
    word_t            z_reg;
    logic [IDX_W-1:0] idx_reg;

    // Generator state words.
    word_t            gen_word_reg [NUM_WORDS];

    // Request and working registers.
    logic             action_reg;
    word_t            lo_reg;
    word_t            hi_reg;
    word_t            span_reg;
    word_t            limit_reg;
    word_t            t_reg;
    word_t            draw_reg;
    word_t            res_reg;

    logic             m_valid_reg;
    sword_t           m_value_reg;

    // Shared unit handshakes.
    logic             mul_start;
    word_t            mul_op_b;
    logic             mul_done;
    word_t            mul_prod;
    logic             div_start;
    word_t            div_dividend;
    logic             div_done;
    word_t            div_rem;

    logic             out_free;
    logic             in_accept;
    logic             in_emit;
    logic             emit_load;
    logic             fraction_use;
    logic             limit_done;
    logic             limit_ok;
    word_t            acc_sum;
    word_t            gen_next [NUM_WORDS];
    word_t            gen_sh;
    word_t            scram_rot;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign acc_sum   = acc_reg + GOLDEN_STEP;

    // The output register is loaded when the emit state finds it free.
    assign in_emit      = (state_reg == ST_EMIT);
    assign emit_load    = in_emit && out_free && !cfg_wr_en;
    assign fraction_use = (state_reg == ST_USE) && (action_reg == ACTION_FRACTION)
                       && !cfg_wr_en;
    assign limit_done   = (state_reg == ST_LIMIT) && div_done;
    assign limit_ok     = (div_rem < span_reg);

    // One xoshiro256** state transition, computed from the current words.
    always_comb begin
        gen_sh      = gen_word_reg[1] << GEN_SHIFT;
        gen_next[2] = gen_word_reg[2] ^ gen_word_reg[0];
        gen_next[3] = gen_word_reg[3] ^ gen_word_reg[1];
        gen_next[1] = gen_word_reg[1] ^ gen_next[2];
        gen_next[0] = gen_word_reg[0] ^ gen_next[3];
        gen_next[2] = gen_next[2] ^ gen_sh;
        gen_next[3] = rotl(gen_next[3], GEN_ROT);
    end

    assign scram_rot = rotl(t_reg, SCRAM_ROT);

    // Multiplier and remainder unit operands follow the state.
    assign mul_start    = (state_reg == ST_MUL_A) || (state_reg == ST_MUL_B);
    assign mul_op_b     = (state_reg == ST_MUL_B) ? MIX_MUL_B : MIX_MUL_A;
    assign div_start    = (state_reg == ST_SPAN && span_reg != '0)
                       || (state_reg == ST_USE && action_reg == ACTION_BOUNDED
                           && span_reg != '0 && draw_reg >= limit_reg);
    assign div_dividend = (state_reg == ST_SPAN) ? ('0 - span_reg) : draw_reg;

    xbr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (z_reg),
        .op_b    (mul_op_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    xbr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Next-state logic. A seed write restarts the expansion from any state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_action == ACTION_FRACTION) ? ST_DRAW1 : ST_DECIDE;
                end
            end
            ST_SEED_ADD: begin
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A: begin
                if (mul_done) begin
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                state_next = ST_WAIT_B;
            end
            ST_WAIT_B: begin
                if (mul_done) begin
                    state_next = (idx_reg == IDX_LAST) ? ST_IDLE : ST_SEED_ADD;
                end
            end
            ST_DECIDE: begin
                state_next = ($signed(lo_reg) > $signed(hi_reg)) ? ST_EMIT : ST_SPAN;
            end
            ST_SPAN: begin
                state_next = (span_reg == '0) ? ST_DRAW1 : ST_LIMIT;
            end
            ST_LIMIT: begin
                if (div_done) begin
                    state_next = ST_DRAW1;
                end
            end
            ST_DRAW1: begin
                state_next = ST_DRAW2;
            end
            ST_DRAW2: begin
                state_next = ST_USE;
            end
            ST_USE: begin
                if (action_reg == ACTION_FRACTION || span_reg == '0) begin
                    state_next = ST_EMIT;
                end else if (draw_reg < limit_reg) begin
                    state_next = ST_DRAW1;
                end else begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en) begin
            state_next = ST_SEED_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SEED_ADD;
            acc_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (m_ready && !emit_load) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                acc_reg <= cfg_wr_data;
                idx_reg <= '0;
            end else begin
                case (state_reg)
                    ST_IDLE: begin
                        if (in_accept) begin
                            action_reg <= s_action;
                            lo_reg     <= word_t'(s_range_low);
                            hi_reg     <= word_t'(s_range_high);
                        end
                    end
                    ST_SEED_ADD: begin
                        // splitmix64: advance, then first xor-shift.
                        acc_reg <= acc_sum;
                        z_reg   <= acc_sum ^ (acc_sum >> MIX_SHIFT_1);
                    end
                    ST_WAIT_A: begin
                        if (mul_done) begin
                            z_reg <= mul_prod ^ (mul_prod >> MIX_SHIFT_2);
                        end
                    end
                    ST_WAIT_B: begin
                        if (mul_done) begin
                            gen_word_reg[idx_reg] <= mul_prod ^ (mul_prod >> MIX_SHIFT_3);
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    ST_DECIDE: begin
                        // Empty interval answers with the lower bound, no draw.
                        res_reg  <= lo_reg;
                        span_reg <= hi_reg - lo_reg + 1'b1;
                    end
                    ST_LIMIT: begin
                        if (div_done) begin
                            limit_reg <= div_rem;
                        end
                    end
                    ST_DRAW1: begin
                        // Scrambler times 5 on the old second word, state steps.
                        t_reg <= gen_word_reg[1] + (gen_word_reg[1] << SCRAM_SHL_5);
                        for (int i = 0; i < NUM_WORDS; i++) begin
                            gen_word_reg[i] <= gen_next[i];
                        end
                    end
                    ST_DRAW2: begin
                        draw_reg <= scram_rot + (scram_rot << SCRAM_SHL_9);
                    end
                    ST_USE: begin
                        if (action_reg == ACTION_FRACTION) begin
                            res_reg <= draw_reg >> FRAC_SHIFT;
                        end else begin
                            res_reg <= draw_reg;
                        end
                    end
                    ST_MOD: begin
                        if (div_done) begin
                            res_reg <= lo_reg + div_rem;
                        end
                    end
                    ST_EMIT: begin
                        if (out_free) begin
                            m_valid_reg <= 1'b1;
                            m_value_reg <= sword_t'(res_reg);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    // An accepted item keeps the block busy on the following cycle.
    `XBR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_accept, !s_ready, "ready after accept")
    // A fraction request never enters the rejection loop.
    `XBR_ASSERT_NEXT(a_fraction_emits, aclk, aresetn, fraction_use, in_emit, "fraction looped")
    // The rejection limit is always below the span.
    `XBR_ASSERT_NOW(a_limit_below_span, aclk, aresetn, limit_done, limit_ok, "limit too large")
    // An output load at the emit state always fills the output register.
    `XBR_ASSERT_NEXT(a_emit_fills, aclk, aresetn, emit_load, m_valid_reg, "result lost at emit")

endmodule

`default_nettype wire

>>> rtl/xbr_mul.sv
// Low half of a 64 by 64 bit product, built from three 32 by 32 bit partial
// products on one shared multiplier. Uses xbr_pkg.
`default_nettype none

module xbr_mul (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire xbr_pkg::word_t op_a,
    input  wire xbr_pkg::word_t op_b,
    output logic               done,
    output xbr_pkg::word_t     product
);
    import xbr_pkg::*;

    localparam logic [1:0] STEP_LOW   = 2'd0;
    localparam logic [1:0] STEP_CROSS = 2'd1;
    localparam logic [1:0] STEP_HIGH  = 2'd2;
    localparam logic [1:0] STEP_LAST  = 2'd3;

    word_t      a_reg;
    word_t      b_reg;
    word_t      pp_reg;
    word_t      acc_reg;
    logic [1:0] step_reg;
    logic       busy_reg;
    logic       done_reg;

    half_t mul_x;
    half_t mul_y;
    word_t mul_prod;

    // Step 0: aL*bL, step 1: aL*bH, step 2: aH*bL. The cross terms only
    // reach the upper half, so aH*bH never matters.
    always_comb begin
        mul_x = (step_reg == STEP_HIGH) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        mul_y = (step_reg == STEP_CROSS) ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
    end

    assign mul_prod = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LOW;
        end else begin
            done_reg <= !start && busy_reg && (step_reg == STEP_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_LOW;
                a_reg    <= op_a;
                b_reg    <= op_b;
            end else if (busy_reg) begin
                pp_reg   <= mul_prod;
                step_reg <= step_reg + 2'd1;
                case (step_reg)
                    STEP_LOW: begin
                    end
                    STEP_CROSS: begin
                        acc_reg <= pp_reg;
                    end
                    STEP_HIGH: begin
                        acc_reg <= acc_reg + {pp_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                    end
                    STEP_LAST: begin
                        acc_reg  <= acc_reg + {pp_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                        busy_reg <= 1'b0;
                    end
                    default: begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> rtl/xbr_div.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one quotient
// bit per cycle. Uses xbr_pkg.
`default_nettype none

module xbr_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire xbr_pkg::word_t dividend,
    input  wire xbr_pkg::word_t divisor,
    output logic                done,
    output xbr_pkg::word_t      remainder
);
    import xbr_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    word_t            dvd_reg;
    word_t            dvs_reg;
    word_t            rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;

    // The partial remainder stays below the divisor, so the shifted value
    // needs one extra bit and the difference always fits back in a word.
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
                rem_reg <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
